/* hdl/mcqme_pkg.sv */
package mcqme_pkg;

  // Action codes of an input item
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EVAL  = 2'd1;
  localparam logic [1:0] ACT_APPLY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_ADJ   = 2'd1;

  // Result status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  vertex_from;
    logic [2:0]  vertex_to;
    logic [12:0] weight;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] min_value;
    logic [31:0] moved_min;
    logic        status;
  } out_t;

  // Edge test on the 8x8 adjacency bits; self-loops never count
  function automatic logic linked(input logic [63:0] adj, input logic [2:0] u,
                                  input logic [2:0] v);
    logic r;
    r = (u != v) && (adj[{u, v}] || adj[{v, u}]);
    return r;
  endfunction

  // Side of vertex v in cut c; vertex 0 always sits on side 0
  function automatic logic side_of(input logic [6:0] c, input logic [2:0] v);
    logic r;
    r = (v == 3'd0) ? 1'b0 : c[v - 3'd1];
    return r;
  endfunction

endpackage

/* hdl/min_cut_quadratic_move_evaluator_unit.sv */
// Channel  | Signals                                  | Handshake
// command  | start, busy, cmd                         | taken when start && !busy
// result   | done, result                             | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data| taken when valid && ready
//
// A load without last answers in the cycle after it is taken.
// Evaluate and apply stream the 2^(n-1) cut rows through the memory read port,
// one row per cycle, apply writing back the row behind.
// A load with last rebuilds every row pair by pair.
// Synchronous reset clears weights, minimum and row valid bits; no sweep.
// Results cannot be held off; busy covers every multi-cycle item.
module min_cut_quadratic_move_evaluator_unit #(
  parameter int VERTICES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mcqme_pkg::in_t    cmd,
  output logic              done,
  output mcqme_pkg::out_t   result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import mcqme_pkg::*;

  localparam int CUTS = 1 << (VERTICES - 1);
  localparam int CB   = VERTICES - 1;
  localparam int VB   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam logic [VB-1:0] VLAST = VB'(VERTICES - 1);
  localparam logic [CB:0]   CLAST = (CB+1)'(CUTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_REC, S_REC_WR, S_SCAN} state_t;

  state_t                    state;
  logic [3:0]                vcount;
  logic [63:0]               adj;
  logic [15:0]               wts [VERTICES];
  logic [31:0]               cur_min;
  logic                      op_apply;
  logic [2:0]                fi, tj;
  logic [VB-1:0]             u, v;
  logic [CB:0]               rcut;
  logic [CB-1:0]             pcut;
  logic                      pval;
  logic [31:0]               acc, best;
  logic [VERTICES-1:0][15:0] mrow;

  logic [3:0]                n;
  logic [CB:0]               cuts;
  logic                      rd_en, wr_en;
  logic [CB-1:0]             rd_addr, wr_addr;
  logic [31:0]               rd_q, wr_q;
  logic [VERTICES-1:0][15:0] rd_m, wr_m, new_row;
  logic                      take, reject, pair_hit;
  logic [31:0]               prod, val, val_best, acc_best;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign take      = start && !busy;

  // Clamp the vertex count to the supported range
  always_comb begin
    if (vcount < 4'd2) n = 4'd2;
    else if (vcount > 4'(VERTICES)) n = 4'(VERTICES);
    else n = vcount;
    cuts = (CB+1)'(1) << (n - 4'd1);
  end

  assign reject = (cmd.vertex_from == cmd.vertex_to) || ({1'b0, cmd.vertex_from} >= n) ||
                  ({1'b0, cmd.vertex_to} >= n) ||
                  (wts[cmd.vertex_from[VB-1:0]] == 16'd0);

  // Rebuild step: one vertex pair of the current cut
  assign pair_hit = (3'(u) < 3'(v)) && ({1'b0, 3'(v)} < n) && (rcut < cuts) &&
                    linked(adj, 3'(u), 3'(v)) &&
                    (side_of(7'(rcut[CB-1:0]), 3'(u)) == side_of(7'(rcut[CB-1:0]), 3'(v)));
  assign prod     = 32'(wts[u]) * 32'(wts[v]);
  assign acc_best = ((rcut < cuts) && (acc < best)) ? acc : best;

  // Moved value and updated row for the cut coming out of memory
  always_comb begin
    logic si, sj;
    logic [2:0] k3;
    si  = side_of(7'(pcut), fi);
    sj  = side_of(7'(pcut), tj);
    val = rd_q - 32'(rd_m[fi[VB-1:0]]) + 32'(rd_m[tj[VB-1:0]]);
    if (linked(adj, fi, tj) && (si == sj)) val = val - 32'd1;
    for (int k = 0; k < VERTICES; k++) begin
      k3 = 3'(k);
      new_row[k] = rd_m[k];
      if (({1'b0, k3} < n) && linked(adj, fi, k3) && (side_of(7'(pcut), k3) == si))
        new_row[k] = new_row[k] - 16'd1;
      if (({1'b0, k3} < n) && linked(adj, tj, k3) && (side_of(7'(pcut), k3) == sj))
        new_row[k] = new_row[k] + 16'd1;
    end
    val_best = (val < best) ? val : best;
  end

  // Memory port control
  always_comb begin
    rd_en   = (state == S_SCAN) && (rcut < cuts);
    rd_addr = rcut[CB-1:0];
    wr_en   = 1'b0;
    wr_addr = pcut;
    wr_q    = val;
    wr_m    = new_row;
    if (state == S_REC_WR) begin
      wr_en   = 1'b1;
      wr_addr = rcut[CB-1:0];
      wr_q    = acc;
      wr_m    = mrow;
    end else if ((state == S_SCAN) && pval && op_apply) begin
      wr_en = 1'b1;
    end
  end

  mcqme_mem #(.VERTICES(VERTICES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (rd_q),
    .rd_m    (rd_m),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_q    (wr_q),
    .wr_m    (wr_m)
  );

  // Sequencer: decode items, rebuild rows, stream moves
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vcount  <= 4'd8;
      adj     <= '0;
      cur_min <= '0;
      done    <= 1'b0;
      pval    <= 1'b0;
      for (int k = 0; k < VERTICES; k++) wts[k] <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNT: vcount <= cfg_data[3:0];
          CFG_ADJ:   adj    <= cfg_data;
          default:   ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            result <= '{min_value: cur_min, moved_min: 32'd0,
                        status: ((cmd.action inside {ACT_EVAL, ACT_APPLY}) && reject) ?
                                ST_REJECT : ST_OK};
            rcut   <= '0;
            u      <= '0;
            v      <= '0;
            acc    <= '0;
            mrow   <= '0;
            best   <= '1;
            pval   <= 1'b0;
            fi     <= cmd.vertex_from;
            tj     <= cmd.vertex_to;
            case (cmd.action)
              ACT_LOAD: begin
                if ({1'b0, cmd.vertex_from} < 4'(VERTICES))
                  wts[cmd.vertex_from[VB-1:0]] <= {3'b000, cmd.weight};
                if (cmd.last) state <= S_REC;
                else done <= 1'b1;
              end
              ACT_EVAL, ACT_APPLY: begin
                op_apply <= (cmd.action == ACT_APPLY);
                if (reject) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_REC: begin
          if (pair_hit) begin
            acc     <= acc + prod;
            mrow[u] <= mrow[u] + wts[v];
            mrow[v] <= mrow[v] + wts[u];
          end
          if (v == VLAST) begin
            v <= '0;
            if (u == VLAST) begin
              u     <= '0;
              state <= S_REC_WR;
            end else begin
              u <= u + VB'(1);
            end
          end else begin
            v <= v + VB'(1);
          end
        end
        S_REC_WR: begin
          acc  <= '0;
          mrow <= '0;
          best <= acc_best;
          rcut <= rcut + (CB+1)'(1);
          if (rcut == CLAST) begin
            cur_min          <= acc_best;
            result.min_value <= acc_best;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            state <= S_REC;
          end
        end
        S_SCAN: begin
          pval <= rd_en;
          pcut <= rd_addr;
          if (rd_en) rcut <= rcut + (CB+1)'(1);
          if (pval) begin
            best <= val_best;
            if (rcut == cuts) begin
              done             <= 1'b1;
              state            <= S_IDLE;
              result.moved_min <= val_best;
              if (op_apply) begin
                cur_min               <= val_best;
                result.min_value      <= val_best;
                wts[fi[VB-1:0]]       <= wts[fi[VB-1:0]] - 16'd1;
                wts[tj[VB-1:0]]       <= wts[tj[VB-1:0]] + 16'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result strobe never overlaps work in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Rows are only written by a multi-cycle item
  a_wr_busy: assert property (@(posedge clk) disable iff (rst) wr_en |-> busy)
    else $error("memory write while idle");

  // Every taken item either answers at once or starts work
  a_take: assert property (@(posedge clk) disable iff (rst) take |=> (done || busy))
    else $error("item dropped");

endmodule

/* hdl/mcqme_mem.sv */
module mcqme_mem #(
  parameter int VERTICES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [VERTICES-2:0]         rd_addr,
  output logic [31:0]                 rd_q,
  output logic [VERTICES-1:0][15:0]   rd_m,
  input  logic                        wr_en,
  input  logic [VERTICES-2:0]         wr_addr,
  input  logic [31:0]                 wr_q,
  input  logic [VERTICES-1:0][15:0]   wr_m
);
  localparam int CUTS = 1 << (VERTICES - 1);

  logic [31:0]               qmem [CUTS];
  logic [VERTICES-1:0][15:0] mmem [CUTS];
  logic [CUTS-1:0]           vld;

  // Mark rows written since reset; unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Write one cut row, read one cut row with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      qmem[wr_addr] <= wr_q;
      mmem[wr_addr] <= wr_m;
    end
    if (rd_en) begin
      rd_q <= vld[rd_addr] ? qmem[rd_addr] : '0;
      rd_m <= vld[rd_addr] ? mmem[rd_addr] : '0;
    end
  end

endmodule

/* tb/min_cut_quadratic_move_evaluator_unit_tb.sv */
module min_cut_quadratic_move_evaluator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcqme_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         cmd;
  logic        done;
  out_t        result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  min_cut_quadratic_move_evaluator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the evaluator state
  logic [15:0] vw[8];
  logic [31:0] cut_q[128];
  logic [15:0] side_sum[128][8];
  logic [31:0] best_cut;
  logic [3:0]  n_reg;
  logic [63:0] adj_reg;

  out_t pending_results[$];
  int   errors;
  bit   no_gaps;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int used_vertices();
    int n;
    n = n_reg;
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic bit is_edge(int u, int v);
    if (u == v) return 1'b0;
    return adj_reg[u * 8 + v] | adj_reg[v * 8 + u];
  endfunction

  function automatic bit side(int c, int v);
    logic [7:0] s;
    s = {c[6:0], 1'b0};
    return s[v];
  endfunction

  function automatic logic [31:0] lowest_cut(int n);
    logic [31:0] b;
    b = 32'hFFFF_FFFF;
    for (int c = 0; c < (1 << (n - 1)); c++)
      if (cut_q[c] < b) b = cut_q[c];
    return b;
  endfunction

  function automatic logic [31:0] shifted_q(int c, int i, int j);
    logic [31:0] val;
    val = cut_q[c] - 32'(side_sum[c][i]) + 32'(side_sum[c][j]);
    if (is_edge(i, j) && side(c, i) == side(c, j)) val = val - 32'd1;
    return val;
  endfunction

  // Full rebuild of every cut sum and same-side sum
  function automatic void rebuild_cuts();
    int n;
    logic [31:0] q;
    n = used_vertices();
    for (int c = 0; c < 128; c++) begin
      cut_q[c] = '0;
      for (int v = 0; v < 8; v++) side_sum[c][v] = '0;
    end
    for (int c = 0; c < (1 << (n - 1)); c++) begin
      q = '0;
      for (int u = 0; u < n; u++)
        for (int v = u + 1; v < n; v++)
          if (is_edge(u, v) && side(c, u) == side(c, v)) begin
            q = q + 32'(vw[u]) * 32'(vw[v]);
            side_sum[c][u] = side_sum[c][u] + vw[v];
            side_sum[c][v] = side_sum[c][v] + vw[u];
          end
      cut_q[c] = q;
    end
    best_cut = lowest_cut(n);
  endfunction

  // Work out the result of one item and advance the shadow state
  function automatic out_t step_evaluator(in_t it);
    out_t r;
    int n, i, j;
    logic [31:0] val;
    bit si, sj;
    n = used_vertices();
    i = it.vertex_from;
    j = it.vertex_to;
    r.moved_min = '0;
    r.status = ST_OK;
    if (it.action == ACT_LOAD) begin
      vw[i] = 16'(it.weight);
      if (it.last) rebuild_cuts();
    end else if (it.action == ACT_EVAL || it.action == ACT_APPLY) begin
      if (i == j || i >= n || j >= n || vw[i] == 0) begin
        r.status = ST_REJECT;
      end else if (it.action == ACT_EVAL) begin
        r.moved_min = 32'hFFFF_FFFF;
        for (int c = 0; c < (1 << (n - 1)); c++) begin
          val = shifted_q(c, i, j);
          if (val < r.moved_min) r.moved_min = val;
        end
      end else begin
        for (int c = 0; c < (1 << (n - 1)); c++) begin
          si = side(c, i);
          sj = side(c, j);
          cut_q[c] = shifted_q(c, i, j);
          for (int u = 0; u < n; u++)
            if (is_edge(i, u) && side(c, u) == si) side_sum[c][u] = side_sum[c][u] - 16'd1;
          for (int u = 0; u < n; u++)
            if (is_edge(j, u) && side(c, u) == sj) side_sum[c][u] = side_sum[c][u] + 16'd1;
        end
        vw[i] = vw[i] - 16'd1;
        vw[j] = vw[j] + 16'd1;
        best_cut = lowest_cut(n);
        r.moved_min = best_cut;
      end
    end
    r.min_value = best_cut;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: actual %h", $time, result);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.min_value !== exp_r.min_value) begin
          $display("%0t: min_value expected %h actual %h", $time, exp_r.min_value,
                   result.min_value);
          errors++;
        end
        if (result.moved_min !== exp_r.moved_min) begin
          $display("%0t: moved_min expected %h actual %h", $time, exp_r.moved_min,
                   result.moved_min);
          errors++;
        end
        if (result.status !== exp_r.status) begin
          $display("%0t: status expected %h actual %h", $time, exp_r.status, result.status);
          errors++;
        end
      end
    end
  end

  // Drive one item, hold it until taken, then sometimes idle a while
  task automatic send_item(logic [1:0] act, int from, int to, int w, bit lst);
    in_t it;
    int g;
    it.action = act;
    it.vertex_from = 3'(from);
    it.vertex_to = 3'(to);
    it.weight = 13'(w);
    it.last = lst;
    @(negedge clk);
    start <= 1'b1;
    cmd <= it;
    do @(posedge clk); while (busy);
    pending_results = {pending_results, step_evaluator(it)};
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write a register while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COUNT) n_reg = val[3:0];
    else if (idx == CFG_ADJ) adj_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all(int max_w);
    for (int v = 0; v < 8; v++) send_item(ACT_LOAD, v, $urandom_range(0, 7),
                                          $urandom_range(0, max_w), v == 7);
  endtask

  // Extremes, every action, rejects, clamping and stale sums
  task automatic test_directed();
    write_reg(CFG_COUNT, 64'd15);
    write_reg(CFG_ADJ, 64'hFFFF_FFFF_FFFF_FFFF);
    load_all(0);
    send_item(ACT_EVAL, 0, 1, 0, 0);
    for (int v = 0; v < 8; v++) send_item(ACT_LOAD, v, 0, v == 0 ? 8191 : 3, v == 7);
    send_item(ACT_EVAL, 0, 7, 8191, 1);
    send_item(ACT_APPLY, 7, 0, 0, 0);
    send_item(ACT_EVAL, 3, 3, 0, 0);
    send_item(2'd3, 5, 2, 8191, 1);
    send_item(ACT_LOAD, 4, 0, 0, 0);
    send_item(ACT_APPLY, 4, 1, 0, 0);
    // Change the graph without a rebuild
    write_reg(CFG_ADJ, 64'h0000_0000_0000_0102);
    send_item(ACT_EVAL, 1, 2, 0, 0);
    send_item(ACT_APPLY, 2, 0, 0, 0);
    write_reg(CFG_COUNT, 64'd0);
    send_item(ACT_APPLY, 0, 1, 0, 0);
    send_item(ACT_EVAL, 0, 2, 0, 0);
    send_item(ACT_LOAD, 1, 0, 5, 1);
    write_reg(CFG_COUNT, 64'd1);
    send_item(ACT_EVAL, 1, 0, 0, 0);
  endtask

  // Rebuild then a run of moves; some noise mixed in
  task automatic test_random_phases(int phases);
    int n, f, t, r;
    for (int p = 0; p < phases; p++) begin
      no_gaps = (p % 5 == 2);
      r = $urandom_range(0, 9);
      write_reg(CFG_COUNT, r == 0 ? 64'($urandom_range(0, 15)) : 64'($urandom_range(2, 8)));
      r = $urandom_range(0, 9);
      write_reg(CFG_ADJ, r == 0 ? 64'hFFFF_FFFF_FFFF_FFFF :
                         r == 1 ? 64'd0 : {$urandom, $urandom});
      n = used_vertices();
      load_all($urandom_range(0, 3) == 0 ? 8191 : 12);
      for (int k = 0; k < 32; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          f = $urandom_range(0, n - 1);
          do t = $urandom_range(0, n - 1); while (t == f);
          send_item($urandom_range(0, 1) ? ACT_APPLY : ACT_EVAL, f, t, $urandom_range(0, 8191),
                    $urandom_range(0, 1));
        end else if (r < 97) begin
          send_item(2'($urandom_range(1, 3)), $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 8191), $urandom_range(0, 1));
        end else begin
          send_item(ACT_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 8191), 1'b0);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Sender waits for every result before going on
  task automatic test_drain_pause();
    send_item(ACT_EVAL, 0, 1, 0, 0);
    wait_drained();
    send_item(ACT_APPLY, 1, 0, 0, 0);
  endtask

  initial begin
    errors = 0;
    no_gaps = 1'b0;
    n_reg = 4'd8;
    adj_reg = '0;
    for (int v = 0; v < 8; v++) vw[v] = '0;
    for (int c = 0; c < 128; c++) begin
      cut_q[c] = '0;
      for (int v = 0; v < 8; v++) side_sum[c][v] = '0;
    end
    best_cut = '0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COUNT;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases(10);
    test_drain_pause();
    test_random_phases(10);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
